/* rtl/setm_pkg.sv */
package setm_pkg;

  // slot layout
  localparam int TASK_SLOTS      = 6;
  localparam int ROUND_FAULT_BIT = 6;
  localparam int SLOT_COUNT      = TASK_SLOTS + 1;

  // field widths
  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int US_W     = 16;
  localparam int MASK_W   = 8;
  localparam int REG_W    = 3;
  localparam int AVG_SHIFT = 3;

  // configuration register indexes
  localparam int REG_COUNT = 7;
  localparam logic [REG_W-1:0] REG_BUDGET_SLOT5 = 3'd5;
  localparam logic [REG_W-1:0] REG_BUDGET_ROUND = 3'd6;

  localparam logic [US_W-1:0] US_MAX = 16'hFFFF;

  localparam logic [US_W-1:0] BUDGET_RESET [REG_COUNT] = '{
    16'd100, 16'd100, 16'd5000, 16'd8000, 16'd20000, 16'd40000, 16'd1000
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_RECORD  = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_CONSUME = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [SLOT_W-1:0] slot_index;
    logic [US_W-1:0]   sample_us;
    logic              round_active;
  } in_item_t;

  typedef struct packed {
    logic              overrun;
    logic [US_W-1:0]   average_us;
    logic [US_W-1:0]   peak_us;
    logic [US_W-1:0]   maximum_us;
    logic [US_W-1:0]   fault_total;
    logic [MASK_W-1:0] sticky_mask;
    logic [MASK_W-1:0] live_mask;
    logic [MASK_W-1:0] event_mask;
  } out_item_t;

  // one item handed from the input stage to the slot core
  typedef struct packed {
    logic     fire;
    in_item_t item;
  } slot_req_t;

endpackage

/* rtl/setm_in_if.sv */
interface setm_in_if;
  import setm_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SLOT_W-1:0] slot_index;
  logic [US_W-1:0]   sample_us;
  logic              round_active;

  modport source (output valid, mode, slot_index, sample_us, round_active, input ready);
  modport sink   (input valid, mode, slot_index, sample_us, round_active, output ready);
endinterface

/* rtl/setm_out_if.sv */
interface setm_out_if;
  import setm_pkg::*;

  logic              valid;
  logic              ready;
  logic              overrun;
  logic [US_W-1:0]   average_us;
  logic [US_W-1:0]   peak_us;
  logic [US_W-1:0]   maximum_us;
  logic [US_W-1:0]   fault_total;
  logic [MASK_W-1:0] sticky_mask;
  logic [MASK_W-1:0] live_mask;
  logic [MASK_W-1:0] event_mask;

  modport source (output valid, overrun, average_us, peak_us, maximum_us, fault_total,
                  sticky_mask, live_mask, event_mask, input ready);
  modport sink   (input valid, overrun, average_us, peak_us, maximum_us, fault_total,
                  sticky_mask, live_mask, event_mask, output ready);
endinterface

/* rtl/setm_cfg_if.sv */
interface setm_cfg_if;
  import setm_pkg::*;

  logic             valid;
  logic             ready;
  logic [REG_W-1:0] index;
  logic [US_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/setm_budget_regs.sv */
module setm_budget_regs (
  input  logic                     clk,
  input  logic                     rst,
  setm_cfg_if.sink                 cfg,
  input  logic [setm_pkg::SLOT_W-1:0] slot_index,
  output logic [setm_pkg::US_W-1:0]   budget
);
  import setm_pkg::*;

  logic [US_W-1:0] budgets [REG_COUNT];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        budgets[i] <= BUDGET_RESET[i];
      end
    end else if (cfg.valid && (4'(cfg.index) < 4'(REG_COUNT))) begin
      budgets[cfg.index] <= cfg.data;
    end
  end

  // round slot has its own register, an extra task slot shares slot 5's
  always_comb begin
    if (4'(slot_index) == 4'(TASK_SLOTS)) begin
      budget = budgets[REG_BUDGET_ROUND];
    end else if (slot_index < REG_BUDGET_ROUND) begin
      budget = budgets[slot_index];
    end else begin
      budget = budgets[REG_BUDGET_SLOT5];
    end
  end
endmodule

/* rtl/setm_slot_core.sv */
module setm_slot_core (
  input  logic                   clk,
  input  logic                   rst,
  input  setm_pkg::slot_req_t    req,
  input  logic [setm_pkg::US_W-1:0] budget,
  output setm_pkg::out_item_t    result
);
  import setm_pkg::*;

  logic [US_W-1:0]   avg_store   [SLOT_COUNT];
  logic [US_W-1:0]   peak_store  [SLOT_COUNT];
  logic [US_W-1:0]   max_store   [SLOT_COUNT];
  logic [US_W-1:0]   fault_store [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] seeded_flags;
  logic [MASK_W-1:0] sticky_bits;
  logic [MASK_W-1:0] live_bits;
  logic [MASK_W-1:0] event_bits;

  logic              slot_ok;
  logic              is_round;
  logic              rec;
  logic              over;
  logic [MASK_W-1:0] slot_bit;
  logic [US_W-1:0]   avg_cur, peak_cur, max_cur, fault_cur;
  logic [US_W-1:0]   avg_next, peak_next, max_next, fault_next;
  logic              seeded_cur;
  logic [US_W-1:0]   us;
  logic [MASK_W-1:0] sticky_next, live_next, event_next;

  assign us       = req.item.sample_us;
  assign slot_ok  = 4'(req.item.slot_index) < 4'(SLOT_COUNT);
  assign is_round = 4'(req.item.slot_index) == 4'(TASK_SLOTS);
  assign rec      = (req.item.mode == MODE_RECORD) && slot_ok &&
                    (!is_round || req.item.round_active);
  assign over     = rec && (us > budget);
  assign slot_bit = is_round ? (MASK_W'(1) << ROUND_FAULT_BIT)
                             : (MASK_W'(1) << req.item.slot_index);

  always_comb begin
    avg_cur    = '0;
    peak_cur   = '0;
    max_cur    = '0;
    fault_cur  = '0;
    seeded_cur = 1'b0;
    if (slot_ok) begin
      avg_cur    = avg_store[req.item.slot_index];
      peak_cur   = peak_store[req.item.slot_index];
      max_cur    = max_store[req.item.slot_index];
      fault_cur  = fault_store[req.item.slot_index];
      seeded_cur = seeded_flags[req.item.slot_index];
    end

    avg_next   = avg_cur;
    peak_next  = peak_cur;
    max_next   = max_cur;
    fault_next = fault_cur;
    if (rec) begin
      // running average: avg - avg/8 + sample/8, first sample seeds it
      avg_next  = seeded_cur ? (avg_cur - (avg_cur >> AVG_SHIFT) + (us >> AVG_SHIFT)) : us;
      peak_next = (us > peak_cur) ? us : peak_cur;
      max_next  = (us > max_cur) ? us : max_cur;
      if (over && (fault_cur != US_MAX)) begin
        fault_next = fault_cur + US_W'(1);
      end
    end

    sticky_next = over ? (sticky_bits | slot_bit) : sticky_bits;
    live_next   = over ? (live_bits | slot_bit) : live_bits;
    event_next  = over ? (event_bits | slot_bit) : event_bits;

    result.overrun     = over;
    result.average_us  = avg_next;
    result.peak_us     = peak_next;
    result.maximum_us  = max_next;
    result.fault_total = fault_next;
    result.sticky_mask = sticky_next;
    result.live_mask   = live_next;
    result.event_mask  = event_next;

    case (req.item.mode)
      MODE_CLEAR: begin
        result.peak_us   = '0;
        result.live_mask = '0;
      end
      MODE_RECORD, MODE_CONSUME, MODE_READ: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        avg_store[i]   <= '0;
        peak_store[i]  <= '0;
        max_store[i]   <= '0;
        fault_store[i] <= '0;
      end
      seeded_flags <= '0;
      sticky_bits  <= '0;
      live_bits    <= '0;
      event_bits   <= '0;
    end else if (req.fire) begin
      case (req.item.mode)
        MODE_RECORD: begin
          if (rec) begin
            avg_store[req.item.slot_index]    <= avg_next;
            peak_store[req.item.slot_index]   <= peak_next;
            max_store[req.item.slot_index]    <= max_next;
            fault_store[req.item.slot_index]  <= fault_next;
            seeded_flags[req.item.slot_index] <= 1'b1;
            sticky_bits <= sticky_next;
            live_bits   <= live_next;
            event_bits  <= event_next;
          end
        end
        MODE_CLEAR: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            peak_store[i] <= '0;
          end
          live_bits <= '0;
        end
        MODE_CONSUME: begin
          event_bits <= '0;
        end
        MODE_READ: begin
        end
        default: begin
        end
      endcase
    end
  end
endmodule

/* rtl/slot_execution_time_monitor_top.sv */
// a result passes through the input register and then the result register after its item's transfer in
// throughput: one item per cycle, sustained while the result side keeps up
// the rate is set by the input register feeding the combinational slot update
// reset (rst, synchronous): stats, flags and masks cleared, budgets reloaded,
// both pipeline registers emptied
module slot_execution_time_monitor_top (
  input  logic      clk,
  input  logic      rst,
  setm_in_if.sink   sample_in,
  setm_out_if.source result,
  setm_cfg_if.sink  cfg
);
  import setm_pkg::*;

  // input register
  logic      s1_valid;
  in_item_t  s1_item;
  // result register
  logic      res_valid;
  out_item_t res_item;

  logic      out_free;
  logic      advance;
  slot_req_t req;
  out_item_t core_result;
  logic [US_W-1:0] budget;

  // the result register can take a new item when empty or being drained
  assign out_free        = !res_valid || result.ready;
  // an item in the input register moves on and commits its state update
  assign advance         = s1_valid && out_free;
  assign sample_in.ready = !s1_valid || out_free;

  assign req.fire = advance;
  assign req.item = s1_item;

  // budget registers, looked up for the slot in the input register
  setm_budget_regs u_budget (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .slot_index (s1_item.slot_index),
    .budget     (budget)
  );

  // per-slot statistics and the three overrun masks
  setm_slot_core u_core (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .budget (budget),
    .result (core_result)
  );

  // input stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_in.ready) begin
      s1_valid <= sample_in.valid;
    end
  end

  // input stage payload, loaded on each transfer
  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      s1_item.mode         <= mode_t'(sample_in.mode);
      s1_item.slot_index   <= sample_in.slot_index;
      s1_item.sample_us    <= sample_in.sample_us;
      s1_item.round_active <= sample_in.round_active;
    end
  end

  // result stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  // result stage payload, held while the sink stalls
  always_ff @(posedge clk) begin
    if (advance) begin
      res_item <= core_result;
    end
  end

  assign result.valid       = res_valid;
  assign result.overrun     = res_item.overrun;
  assign result.average_us  = res_item.average_us;
  assign result.peak_us     = res_item.peak_us;
  assign result.maximum_us  = res_item.maximum_us;
  assign result.fault_total = res_item.fault_total;
  assign result.sticky_mask = res_item.sticky_mask;
  assign result.live_mask   = res_item.live_mask;
  assign result.event_mask  = res_item.event_mask;
endmodule

/* rtl/setm_checker.sv */
module setm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          overrun,
  input logic [setm_pkg::US_W-1:0]     fault_total,
  input logic [setm_pkg::MASK_W-1:0]   sticky_mask,
  input logic [setm_pkg::MASK_W-1:0]   live_mask
);
  import setm_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(fault_total) && $stable(sticky_mask))
    else $error("result changed while stalled");

  // an overrun always leaves a nonzero fault count
  a_fault: assert property (@(posedge clk) disable iff (rst)
    res_valid && overrun |-> fault_total != '0)
    else $error("overrun without fault count");

  // an overrun always shows in sticky and live masks
  a_masks: assert property (@(posedge clk) disable iff (rst)
    res_valid && overrun |-> (sticky_mask != '0) && (live_mask != '0))
    else $error("overrun without mask bits");

  // live bits are a subset of sticky bits
  a_subset: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (live_mask & ~sticky_mask) == '0)
    else $error("live bit without sticky bit");
endmodule

bind slot_execution_time_monitor_top setm_checker u_setm_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .overrun     (result.overrun),
  .fault_total (result.fault_total),
  .sticky_mask (result.sticky_mask),
  .live_mask   (result.live_mask)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import setm_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 8;      // margin for a result to pass the input and result registers
  localparam int LONG_HOLD      = 80;     // result side held off long enough to back up the input
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BURST_ITEMS    = 250;
  localparam int STREAK_ITEMS   = 200;    // run of overruns on one slot, with a periodic read
  localparam int PRINT_CAP      = 30;
  localparam logic [REG_W-1:0] REG_UNUSED = REG_W'(REG_COUNT);

  // one pending input item, optionally held back until the block has drained
  typedef struct {
    in_item_t item;
    bit       wait_drained;
  } queued_probe_t;

  logic clk = 1'b0;
  logic rst;

  setm_in_if  sample_in ();
  setm_out_if result ();
  setm_cfg_if cfg ();

  slot_execution_time_monitor_top u_top (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_in),
    .result    (result),
    .cfg       (cfg)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the monitor: budgets, per-slot stats and the three overrun masks
  logic [US_W-1:0]   budget_us  [REG_COUNT];
  logic [US_W-1:0]   avg_now    [SLOT_COUNT];
  logic [US_W-1:0]   peak_now   [SLOT_COUNT];
  logic [US_W-1:0]   max_seen   [SLOT_COUNT];
  logic [US_W-1:0]   fault_cnt  [SLOT_COUNT];
  bit                seeded     [SLOT_COUNT];
  logic [MASK_W-1:0] sticky_now;
  logic [MASK_W-1:0] live_now;
  logic [MASK_W-1:0] event_now;

  queued_probe_t pending_q [$];   // items waiting for the input driver
  out_item_t     due_stats_q [$]; // predicted results, oldest first

  int fail_count   = 0;
  int quiet_cycles = 0;
  bit in_taken     = 1'b0;  // input transfer at the last rising edge
  bit idling_on    = 1'b1;
  bit long_hold_req = 1'b0;
  int send_gap  = 0;
  int stall_left = 0;
  int hold_left = 0;
  int src_calm  = 0;
  int sink_calm = 0;

  // budget that applies to a slot; slot index 7 would share slot 5's
  function automatic logic [US_W-1:0] budget_for(int s);
    if (s == TASK_SLOTS) return budget_us[REG_BUDGET_ROUND];
    if (s < REG_BUDGET_ROUND) return budget_us[s];
    return budget_us[REG_BUDGET_SLOT5];
  endfunction

  // advance the shadow by one input item and return the stats it should produce
  function automatic out_item_t forecast_slot_update(in_item_t it);
    out_item_t         r;
    int                s;
    bit                in_range;
    logic [US_W:0]     blend;
    logic [MASK_W-1:0] hit;
    logic [MASK_W-1:0] ev_before;
    r         = '0;
    s         = it.slot_index;
    in_range  = s < SLOT_COUNT;
    ev_before = event_now;
    case (it.mode)
      MODE_RECORD: begin
        // an inactive round record and an unknown slot leave everything alone
        if (in_range && (s != TASK_SLOTS || it.round_active)) begin
          if (!seeded[s]) begin
            avg_now[s] = it.sample_us;
            seeded[s]  = 1'b1;
          end else begin
            blend = avg_now[s] - (avg_now[s] >> AVG_SHIFT) + (it.sample_us >> AVG_SHIFT);
            avg_now[s] = blend[US_W-1:0];
          end
          if (it.sample_us > peak_now[s]) peak_now[s] = it.sample_us;
          if (it.sample_us > max_seen[s]) max_seen[s] = it.sample_us;
          if (it.sample_us > budget_for(s)) begin
            hit = '0;
            hit[(s == TASK_SLOTS) ? ROUND_FAULT_BIT : s] = 1'b1;
            r.overrun = 1'b1;
            if (fault_cnt[s] != US_MAX) fault_cnt[s] = fault_cnt[s] + 1'b1;
            sticky_now = sticky_now | hit;
            live_now   = live_now | hit;
            event_now  = event_now | hit;
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) peak_now[i] = '0;
        live_now = '0;
      end
      MODE_CONSUME: event_now = '0;
      default: ;
    endcase
    if (in_range) begin
      r.average_us  = avg_now[s];
      r.peak_us     = peak_now[s];
      r.maximum_us  = max_seen[s];
      r.fault_total = fault_cnt[s];
    end
    r.sticky_mask = sticky_now;
    r.live_mask   = live_now;
    r.event_mask  = (it.mode == MODE_CONSUME) ? ev_before : event_now;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  task automatic check_stats(out_item_t got, out_item_t want);
    if (got.overrun !== want.overrun) report_mismatch("overrun", got.overrun, want.overrun);
    if (got.average_us !== want.average_us)
      report_mismatch("average_us", got.average_us, want.average_us);
    if (got.peak_us !== want.peak_us) report_mismatch("peak_us", got.peak_us, want.peak_us);
    if (got.maximum_us !== want.maximum_us)
      report_mismatch("maximum_us", got.maximum_us, want.maximum_us);
    if (got.fault_total !== want.fault_total)
      report_mismatch("fault_total", got.fault_total, want.fault_total);
    if (got.sticky_mask !== want.sticky_mask)
      report_mismatch("sticky_mask", got.sticky_mask, want.sticky_mask);
    if (got.live_mask !== want.live_mask)
      report_mismatch("live_mask", got.live_mask, want.live_mask);
    if (got.event_mask !== want.event_mask)
      report_mismatch("event_mask", got.event_mask, want.event_mask);
  endtask

  // idle pattern shared by both sides: quiet stretches, otherwise random short bursts
  task automatic roll_idle(inout int calm, input int odds, output int burst);
    burst = 0;
    if (calm > 0) calm--;
    else if ($urandom_range(0, 59) == 0) calm = $urandom_range(30, 120);
    else if ($urandom_range(0, odds - 1) == 0) burst = $urandom_range(1, 12);
  endtask

  task automatic queue_probe(mode_t m, int s, int us, bit act, bit drained = 1'b0);
    queued_probe_t q;
    q.item.mode         = m;
    q.item.slot_index   = s[SLOT_W-1:0];
    q.item.sample_us    = us[US_W-1:0];
    q.item.round_active = act;
    q.wait_drained      = drained;
    pending_q.push_back(q);
  endtask

  // random item, mostly records, with many samples near the slot budget
  task automatic queue_random_probe(bit drained);
    mode_t m;
    int    s;
    int    us;
    int    pick;
    pick = $urandom_range(0, 99);
    m = (pick < 72) ? MODE_RECORD : (pick < 80) ? MODE_CLEAR :
        (pick < 90) ? MODE_CONSUME : MODE_READ;
    s = ($urandom_range(0, 15) == 0) ? 7 : $urandom_range(0, SLOT_COUNT - 1);
    case ($urandom_range(0, 5))
      0:       us = $urandom_range(0, 1) ? US_MAX : 0;
      1, 2:    us = int'(budget_for(s)) + $urandom_range(0, 6) - 3;
      3:       us = $urandom_range(0, 65535);
      4:       us = $urandom_range(0, 255);
      default: us = int'(budget_for(s)) / 2 + $urandom_range(0, int'(budget_for(s)) + 1);
    endcase
    if (us < 0) us = 0;
    if (us > US_MAX) us = US_MAX;
    queue_probe(m, s, us, $urandom_range(0, 3) != 0, drained);
  endtask

  task automatic queue_random_burst(int n, int drain_at);
    for (int i = 0; i < n; i++) queue_random_probe(i == drain_at);
  endtask

  // register write on the config channel, only ever issued while the block is idle
  task automatic write_budget(logic [REG_W-1:0] idx, logic [US_W-1:0] val);
    @(negedge clk);
    cfg.index <= idx;
    cfg.data  <= val;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // wait for every queued item to go in and every result to come out
  task automatic settle();
    while (pending_q.size() != 0 || due_stats_q.size() != 0 || sample_in.valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver: holds an offer until its transfer, then takes the next item
  always @(negedge clk) begin : probe_driver
    queued_probe_t nxt;
    int            burst;
    if (rst) begin
      sample_in.valid <= 1'b0;
    end else if (!(sample_in.valid && !in_taken)) begin
      if (send_gap == 0 && idling_on) begin
        roll_idle(src_calm, 8, burst);
        send_gap = burst;
      end
      if (send_gap > 0) begin
        send_gap--;
        sample_in.valid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   (!pending_q[0].wait_drained || due_stats_q.size() == 0)) begin
        nxt = pending_q.pop_front();
        sample_in.mode         <= nxt.item.mode;
        sample_in.slot_index   <= nxt.item.slot_index;
        sample_in.sample_us    <= nxt.item.sample_us;
        sample_in.round_active <= nxt.item.round_active;
        sample_in.valid        <= 1'b1;
      end else begin
        sample_in.valid <= 1'b0;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin : result_sink
    int burst;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left == 0 && stall_left == 0 && idling_on) begin
        roll_idle(sink_calm, 12, burst);
        stall_left = burst;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // monitor: budget writes, input transfers and result transfers at the rising edge
  always @(posedge clk) begin : stats_monitor
    in_item_t  seen;
    out_item_t got;
    out_item_t want;
    bit        cfg_taken;
    bit        out_taken;
    in_taken  = !rst && sample_in.valid && sample_in.ready;
    cfg_taken = !rst && cfg.valid && cfg.ready;
    out_taken = !rst && result.valid && result.ready;
    if (cfg_taken && cfg.index < REG_COUNT) budget_us[cfg.index] = cfg.data;
    // check before predicting: no result can belong to an item taken this edge
    if (out_taken) begin
      got.overrun     = result.overrun;
      got.average_us  = result.average_us;
      got.peak_us     = result.peak_us;
      got.maximum_us  = result.maximum_us;
      got.fault_total = result.fault_total;
      got.sticky_mask = result.sticky_mask;
      got.live_mask   = result.live_mask;
      got.event_mask  = result.event_mask;
      if (due_stats_q.size() == 0) begin
        report_mismatch("result with nothing pending", got.average_us, 0);
      end else begin
        want = due_stats_q.pop_front();
        check_stats(got, want);
      end
    end
    if (in_taken) begin
      seen.mode         = mode_t'(sample_in.mode);
      seen.slot_index   = sample_in.slot_index;
      seen.sample_us    = sample_in.sample_us;
      seen.round_active = sample_in.round_active;
      due_stats_q.push_back(forecast_slot_update(seen));
    end
    // watchdog: too long without any transfer on any channel
    if (rst || in_taken || cfg_taken || out_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : run_phases
    // every input known from time zero
    rst                    = 1'b1;
    sample_in.valid        = 1'b0;
    sample_in.mode         = MODE_READ;
    sample_in.slot_index   = '0;
    sample_in.sample_us    = '0;
    sample_in.round_active = 1'b0;
    result.ready           = 1'b0;
    cfg.valid              = 1'b0;
    cfg.index              = '0;
    cfg.data               = '0;
    for (int i = 0; i < REG_COUNT; i++) budget_us[i] = BUDGET_RESET[i];
    for (int i = 0; i < SLOT_COUNT; i++) begin
      avg_now[i]   = '0;
      peak_now[i]  = '0;
      max_seen[i]  = '0;
      fault_cnt[i] = '0;
      seeded[i]    = 1'b0;
    end
    sticky_now = '0;
    live_now   = '0;
    event_now  = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part under the reset budgets
    queue_probe(MODE_READ, 0, 0, 1'b0);            // unseeded slot reads all zero
    queue_probe(MODE_RECORD, 0, 100, 1'b1);        // seeds, exactly on budget
    queue_probe(MODE_RECORD, 0, 101, 1'b1);        // just over budget
    queue_probe(MODE_RECORD, 1, 0, 1'b0);          // zero sample seeds
    queue_probe(MODE_RECORD, 1, US_MAX, 1'b1);     // largest sample into the average
    queue_probe(MODE_RECORD, 6, US_MAX, 1'b0);     // inactive round record is dropped
    queue_probe(MODE_RECORD, 6, 1001, 1'b1);       // round overrun sets the round bit
    queue_probe(MODE_RECORD, 6, 1000, 1'b1);
    queue_probe(MODE_RECORD, 7, US_MAX, 1'b1);     // unknown slot ignored
    queue_probe(MODE_READ, 7, 1234, 1'b1);
    queue_probe(MODE_CONSUME, 7, 0, 1'b0);         // global action despite unknown slot
    queue_probe(MODE_CONSUME, 0, US_MAX, 1'b1);    // nothing left to consume
    queue_probe(MODE_CLEAR, 3, 0, 1'b1);
    queue_probe(MODE_READ, 0, 0, 1'b0);            // peak gone, maximum kept
    queue_probe(MODE_RECORD, 2, 5001, 1'b1);
    queue_probe(MODE_RECORD, 3, 8001, 1'b0);
    queue_probe(MODE_RECORD, 4, 20001, 1'b1);
    queue_probe(MODE_RECORD, 5, 40001, 1'b1);
    queue_probe(MODE_RECORD, 5, US_MAX, 1'b0);
    queue_probe(MODE_READ, 6, 16'h5A5A, 1'b1);     // sample and flag ignored on read
    queue_probe(MODE_CLEAR, 7, US_MAX, 1'b1);
    queue_probe(MODE_CONSUME, 6, 0, 1'b0);
    queue_probe(MODE_RECORD, 4, 0, 1'b1);
    settle();

    // every budget at zero; the unused register index is written too
    for (int r = 0; r < REG_COUNT; r++) write_budget(REG_W'(r), '0);
    write_budget(REG_UNUSED, US_W'($urandom));
    queue_random_burst(BURST_ITEMS, -1);
    settle();

    // every budget at its ceiling
    for (int r = 0; r < REG_COUNT; r++) write_budget(REG_W'(r), US_MAX);
    queue_random_burst(BURST_ITEMS, -1);
    settle();

    // random budgets, with the long result hold-off and one drained pause
    for (int r = 0; r < REG_COUNT; r++)
      write_budget(REG_W'(r), $urandom_range(0, 1) ? US_W'($urandom_range(0, 2000))
                                                    : US_W'($urandom));
    queue_random_burst(BURST_ITEMS, BURST_ITEMS / 2);
    long_hold_req = 1'b1;
    settle();

    // back to the reset values
    for (int r = 0; r < REG_COUNT; r++) write_budget(REG_W'(r), BUDGET_RESET[r]);
    queue_random_burst(BURST_ITEMS, -1);
    settle();

    // last part runs with no idling on either side
    idling_on = 1'b0;

    // long run of overruns on slot 0, with a read every 64th item
    write_budget(REG_W'(0), '0);
    for (int i = 0; i < STREAK_ITEMS; i++) begin
      if (i % 64 == 63) queue_probe(MODE_READ, 0, 0, 1'b0);
      else queue_probe(MODE_RECORD, 0, $urandom_range(1, 65535), $urandom_range(0, 1));
    end
    settle();

    for (int r = 0; r < REG_COUNT; r++) write_budget(REG_W'(r), US_W'($urandom));
    queue_random_burst(BURST_ITEMS, -1);
    settle();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/setm_pkg.sv
rtl/setm_in_if.sv
rtl/setm_out_if.sv
rtl/setm_cfg_if.sv
rtl/setm_budget_regs.sv
rtl/setm_slot_core.sv
rtl/slot_execution_time_monitor_top.sv
rtl/setm_checker.sv
tb/tb.sv
